@@ sv/ictf_pkg.sv @@
// Shared types, widths and constants for the complementary tilt filter.
// No dependencies; imported by every module of the block.
package ictf_pkg;

   localparam int RAW_W   = 16;   // raw sensor field
   localparam int AXIS_W  = 17;   // raw value after negation (+32768 fits)
   localparam int CX_W    = 36;   // CORDIC x/y datapath
   localparam int CZ_W    = 26;   // CORDIC angle, Q16 degrees
   localparam int ANG_W   = 32;   // output angle, Q15.16
   localparam int ROOT_W  = 32;
   localparam int MAG2_W  = 32;
   localparam int ATAN_LEN = 24;
   localparam int STEP_W  = 5;
   localparam int ATAN_W  = 23;
   localparam int GDIV_W  = 18;

   localparam logic [GDIV_W-1:0] GYRO_DIV  = 18'd131000;  // 131 counts/dps * 1000 ms
   localparam int                GYRO_BIAS = 65500;       // rounds half away from zero
   localparam logic signed [CZ_W-1:0] DEG90 = 26'sd5898240;

   // atan(2^-i) in degrees, Q16, rounded to nearest
   function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      unique case (idx)
         5'd0:  v = 23'd2949120;
         5'd1:  v = 23'd1740967;
         5'd2:  v = 23'd919879;
         5'd3:  v = 23'd466945;
         5'd4:  v = 23'd234379;
         5'd5:  v = 23'd117304;
         5'd6:  v = 23'd58666;
         5'd7:  v = 23'd29335;
         5'd8:  v = 23'd14668;
         5'd9:  v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         5'd17: v = 23'd29;
         5'd18: v = 23'd14;
         5'd19: v = 23'd7;
         5'd20: v = 23'd4;
         5'd21: v = 23'd2;
         5'd22: v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/ictf_isqrt.sv @@
// Bit-serial integer square root of (radicand * 2^32), one root bit per cycle.
// Depends on ictf_pkg.
module ictf_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ictf_pkg::MAG2_W-1:0]   radicand,
   output logic                          busy,
   output logic [ictf_pkg::ROOT_W-1:0]   root
);
   import ictf_pkg::*;

   logic [MAG2_W-1:0] rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [4:0]        cnt_ff;
   logic              busy_ff;

   logic [ROOT_W+3:0] rem_sh;
   logic [ROOT_W+3:0] trial;
   logic              ge;

   assign rem_sh = {rem_ff, rad_ff[MAG2_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         // low half of the radicand is zero: zeros shift in behind it
         rad_ff  <= {rad_ff[MAG2_W-3:0], 2'b00};
         rem_ff  <= ge ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], ge};
         cnt_ff  <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROOT_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

@@ sv/ictf_cdiv.sv @@
// Restoring divider by the gyro scale constant, one quotient bit per cycle.
// Depends on ictf_pkg.
module ictf_cdiv #(
   parameter int NUM_W = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);
   import ictf_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0]  num_ff;   // dividend out at the top, quotient in at the bottom
   logic [GDIV_W-1:0] rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;

   logic [GDIV_W:0] rem_sh;
   logic            ge;

   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, GYRO_DIV};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         num_ff  <= dividend;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? GDIV_W'(rem_sh - {1'b0, GYRO_DIV}) : rem_sh[GDIV_W-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

@@ sv/ictf_cordic.sv @@
// Iterative CORDIC vectoring: atan2(y, x) in Q16 degrees, one rotation a cycle.
// Depends on ictf_pkg.
module ictf_cordic #(
   parameter int STEPS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ictf_pkg::CX_W-1:0]   y_in,
   input  logic signed [ictf_pkg::CX_W-1:0]   x_in,
   output logic                               busy,
   output logic signed [ictf_pkg::CZ_W-1:0]   angle
);
   import ictf_pkg::*;

   localparam int NSTEP = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;

   logic signed [CX_W-1:0] x_ff, y_ff;
   logic signed [CZ_W-1:0] z_ff;
   logic [STEP_W-1:0]      idx_ff;
   logic                   busy_ff;

   logic signed [CX_W-1:0] dx, dy;
   logic signed [CZ_W-1:0] at;

   assign dx = y_ff >>> idx_ff;
   assign dy = x_ff >>> idx_ff;
   assign at = signed'({{(CZ_W-ATAN_W){1'b0}}, atan_q16(idx_ff)});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         idx_ff <= '0;
         if (x_in == '0 && y_in == '0) begin
            // zero vector: angle is zero, no rotations
            z_ff    <= '0;
            busy_ff <= 1'b0;
         end else begin
            busy_ff <= 1'b1;
            priority if (x_in < 0 && y_in >= 0) begin
               x_ff <= y_in;
               y_ff <= -x_in;
               z_ff <= DEG90;
            end else if (x_in < 0) begin
               x_ff <= -y_in;
               y_ff <= x_in;
               z_ff <= -DEG90;
            end else begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= '0;
            end
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end
         idx_ff <= idx_ff + STEP_W'(1);
         if (idx_ff == STEP_W'(NSTEP - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy  = busy_ff;
   assign angle = z_ff;

endmodule

@@ sv/imu_complementary_tilt_filter_core.sv @@
// Complementary pitch/roll filter top level: sequencer, blend and stores.
// Depends on ictf_pkg, ictf_isqrt, ictf_cdiv, ictf_cordic.
//
//  channel | ports          | direction | beat
//  --------+----------------+-----------+---------------------------------
//  req     | req_valid/ready| in        | one raw sample, time, read flag
//  rsp     | rsp_valid/ready| out       | pitch, roll, validity flags
//  csr     | csr_we         | in        | one register write, no wait
//
// A good read's time is set by the bit-serial gyro divider (NUM_W = 33 + dt
// width), the pitch CORDIC pass and the blend steps; a failed read goes
// straight to S_DONE. rsp_valid rises together with req_ready for the next
// beat. One beat is in flight at a time; the next is taken while the result
// still waits in the rsp register.
// Synchronous reset restores register defaults and clears the stores.
module imu_complementary_tilt_filter_core #(
   parameter int CORDIC_STEPS  = 16,
   parameter int MAX_GAP_MS    = 200,
   parameter int DEFAULT_DT_MS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [ictf_pkg::RAW_W-1:0] req_accel_x,
   input  logic signed [ictf_pkg::RAW_W-1:0] req_accel_y,
   input  logic signed [ictf_pkg::RAW_W-1:0] req_accel_z,
   input  logic signed [ictf_pkg::RAW_W-1:0] req_gyro_x,
   input  logic signed [ictf_pkg::RAW_W-1:0] req_gyro_y,
   input  logic [31:0]                       req_now_ms,
   input  logic                              req_read_ok,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ictf_pkg::ANG_W-1:0] rsp_pitch_angle,
   output logic signed [ictf_pkg::ANG_W-1:0] rsp_roll_angle,
   output logic                              rsp_sample_valid,
   output logic                              rsp_update_ok,
   input  logic                              csr_we,
   input  logic [2:0]                        csr_index,
   input  logic [15:0]                       csr_wdata
);
   import ictf_pkg::*;

   localparam int DT_MAX = (MAX_GAP_MS > DEFAULT_DT_MS) ? MAX_GAP_MS : DEFAULT_DT_MS;
   localparam int DT_W   = $clog2(DT_MAX + 1);
   localparam int MAG_W  = RAW_W + DT_W;
   localparam int NUM_W  = MAG_W + 17;
   localparam int INC_W  = MAG_W + 1;
   localparam int MA_W   = 34;
   localparam int MB_W   = 18;
   localparam int PR_W   = MA_W + MB_W;

   localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
   localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

   typedef enum logic [2:0] {
      CSR_ALPHA, CSR_PITCH_NEG, CSR_ROLL_NEG, CSR_AXIS_NEG, CSR_STALE
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_SUM, S_RUN1, S_WAIT1, S_RUN2, S_WAIT2, S_BLEND, S_DONE
   } state_type;

   // configuration
   logic [15:0] alpha_ff;
   logic        pitch_neg_ff, roll_neg_ff;
   logic [5:0]  axis_neg_ff;
   logic [15:0] stale_ff;

   // stores
   logic signed [ANG_W-1:0] pitch_ff, roll_ff;
   logic [31:0]             last_ff;
   logic                    vflag_ff;

   state_type state_ff;
   logic [2:0] bstep_ff;

   // sample in work
   logic signed [AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic [RAW_W-1:0]         gpa_ff, gra_ff;
   logic                     gpn_ff, grn_ff;
   logic [DT_W-1:0]          dt_ff;
   logic [31:0]              now_ff;
   logic                     ok_ff;
   logic [30:0]              sqa_ff, sqb_ff;
   logic [MAG_W-1:0]         magp_ff, magr_ff;
   logic [MAG2_W-1:0]        mag2_ff;
   logic signed [INC_W-1:0]  incp_ff, incr_ff;
   logic signed [CZ_W-1:0]   accp_ff, accr_ff;
   logic signed [PR_W-1:0]   prod_ff, sum_ff;

   logic                    rsp_valid_ff;
   logic signed [ANG_W-1:0] rsp_pitch_ff, rsp_roll_ff;
   logic                    rsp_sv_ff, rsp_uo_ff;

   // accept-side arithmetic
   logic signed [AXIS_W-1:0] ax_s, ay_s, az_s, gx_s, gy_s, gp_s, gr_s, gp_m, gr_m;
   logic [31:0]     gap;
   logic            use_gap;
   logic [DT_W-1:0] dt_sel;

   function automatic logic signed [AXIS_W-1:0] sneg(input logic signed [RAW_W-1:0] v,
                                                     input logic n);
      logic signed [AXIS_W-1:0] e;
      e = {v[RAW_W-1], v};
      return n ? -e : e;
   endfunction

   assign ax_s = sneg(req_accel_x, axis_neg_ff[0]);
   assign ay_s = sneg(req_accel_y, axis_neg_ff[1]);
   assign az_s = sneg(req_accel_z, axis_neg_ff[2]);
   assign gx_s = sneg(req_gyro_x, axis_neg_ff[3]);
   assign gy_s = sneg(req_gyro_y, axis_neg_ff[4]);
   assign gp_s = pitch_neg_ff ? -gy_s : gy_s;
   assign gr_s = roll_neg_ff ? -gx_s : gx_s;
   assign gp_m = -gp_s;
   assign gr_m = -gr_s;

   assign gap     = req_now_ms - last_ff;
   assign use_gap = (last_ff != '0) && (req_now_ms > last_ff) && (gap <= 32'(MAX_GAP_MS));
   assign dt_sel  = use_gap ? gap[DT_W-1:0] : DT_W'(DEFAULT_DT_MS);

   // units
   logic sq_start, dv_start, cd_start;
   logic sq_busy, dvp_busy, dvr_busy, cd_busy;
   logic [ROOT_W-1:0]       root;
   logic [NUM_W-1:0]        qp, qr, nump, numr;
   logic signed [CX_W-1:0]  cd_y, cd_x;
   logic signed [CZ_W-1:0]  cd_z;
   logic signed [AXIS_W-1:0] nax;

   assign sq_start = (state_ff == S_RUN1);
   assign dv_start = (state_ff == S_RUN1);
   assign cd_start = (state_ff == S_RUN1) || (state_ff == S_RUN2);
   assign nump = {1'b0, magp_ff, 16'h0000} + NUM_W'(GYRO_BIAS);
   assign numr = {1'b0, magr_ff, 16'h0000} + NUM_W'(GYRO_BIAS);
   assign nax  = -ax_ff;
   assign cd_y = (state_ff == S_RUN2) ? {{(CX_W-AXIS_W-16){nax[AXIS_W-1]}}, nax, 16'h0000}
                                      : {{(CX_W-AXIS_W-16){ay_ff[AXIS_W-1]}}, ay_ff, 16'h0000};
   assign cd_x = (state_ff == S_RUN2) ? {{(CX_W-ROOT_W){1'b0}}, root}
                                      : {{(CX_W-AXIS_W-16){az_ff[AXIS_W-1]}}, az_ff, 16'h0000};

   ictf_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(mag2_ff),
      .busy(sq_busy), .root(root)
   );

   ictf_cdiv #(.NUM_W(NUM_W)) u_div_pitch (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(nump),
      .busy(dvp_busy), .quotient(qp)
   );

   ictf_cdiv #(.NUM_W(NUM_W)) u_div_roll (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(numr),
      .busy(dvr_busy), .quotient(qr)
   );

   ictf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cd_start), .y_in(cd_y), .x_in(cd_x),
      .busy(cd_busy), .angle(cd_z)
   );

   // narrow products and gyro increments
   logic signed [2*AXIS_W-1:0] sqa_full, sqb_full;
   logic [MAG_W-1:0]           magp_prod, magr_prod;
   logic signed [INC_W-1:0]    qp_s, qr_s;
   logic signed [CZ_W-1:0]     cd_z_neg;

   assign sqa_full  = ay_ff * ay_ff;
   assign sqb_full  = az_ff * az_ff;
   assign magp_prod = gpa_ff * dt_ff;
   assign magr_prod = gra_ff * dt_ff;
   assign qp_s      = signed'({1'b0, qp[MAG_W-1:0]});
   assign qr_s      = signed'({1'b0, qr[MAG_W-1:0]});
   assign cd_z_neg  = -cd_z;

   // blend: one multiply a cycle
   logic signed [MA_W-1:0] ma;
   logic signed [MB_W-1:0] mb;
   logic signed [PR_W-1:0] prod_in;
   logic [16:0]            beta;
   logic signed [PR_W:0]   bsum;
   logic signed [36:0]     bsh;
   logic signed [ANG_W-1:0] bsat;

   assign beta = 17'd65536 - {1'b0, alpha_ff};

   always_comb begin
      unique case (bstep_ff)
         3'd0: begin
            ma = {{(MA_W-ANG_W){pitch_ff[ANG_W-1]}}, pitch_ff}
                 + {{(MA_W-INC_W){incp_ff[INC_W-1]}}, incp_ff};
            mb = {2'b00, alpha_ff};
         end
         3'd1: begin
            ma = {{(MA_W-CZ_W){accp_ff[CZ_W-1]}}, accp_ff};
            mb = {1'b0, beta};
         end
         3'd2: begin
            ma = {{(MA_W-ANG_W){roll_ff[ANG_W-1]}}, roll_ff}
                 + {{(MA_W-INC_W){incr_ff[INC_W-1]}}, incr_ff};
            mb = {2'b00, alpha_ff};
         end
         default: begin
            ma = {{(MA_W-CZ_W){accr_ff[CZ_W-1]}}, accr_ff};
            mb = {1'b0, beta};
         end
      endcase
   end

   assign prod_in = ma * mb;
   assign bsum = {sum_ff[PR_W-1], sum_ff} + {prod_ff[PR_W-1], prod_ff}
                 + (PR_W+1)'(32768);
   assign bsh  = bsum[PR_W:16];

   always_comb begin
      priority if (bsh > SAT_HI) begin
         bsat = SAT_HI[ANG_W-1:0];
      end else if (bsh < SAT_LO) begin
         bsat = SAT_LO[ANG_W-1:0];
      end else begin
         bsat = bsh[ANG_W-1:0];
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= 16'd64225;
         pitch_neg_ff <= 1'b0;
         roll_neg_ff  <= 1'b0;
         axis_neg_ff  <= '0;
         stale_ff     <= 16'd500;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ALPHA:     alpha_ff     <= csr_wdata;
            CSR_PITCH_NEG: pitch_neg_ff <= csr_wdata[0];
            CSR_ROLL_NEG:  roll_neg_ff  <= csr_wdata[0];
            CSR_AXIS_NEG:  axis_neg_ff  <= csr_wdata[5:0];
            CSR_STALE:     stale_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bstep_ff     <= '0;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         last_ff      <= '0;
         vflag_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_DONE the result register is reloaded below instead
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff  <= ax_s;
                  ay_ff  <= ay_s;
                  az_ff  <= az_s;
                  gpn_ff <= gp_s[AXIS_W-1];
                  grn_ff <= gr_s[AXIS_W-1];
                  gpa_ff <= gp_s[AXIS_W-1] ? gp_m[RAW_W-1:0] : gp_s[RAW_W-1:0];
                  gra_ff <= gr_s[AXIS_W-1] ? gr_m[RAW_W-1:0] : gr_s[RAW_W-1:0];
                  dt_ff  <= dt_sel;
                  now_ff <= req_now_ms;
                  ok_ff  <= req_read_ok;
                  if (req_read_ok) begin
                     state_ff <= S_SQ;
                  end else begin
                     // failed read: angles kept, only staleness re-evaluated
                     vflag_ff <= gap < {16'h0000, stale_ff};
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SQ: begin
               sqa_ff   <= sqa_full[30:0];
               sqb_ff   <= sqb_full[30:0];
               magp_ff  <= magp_prod;
               magr_ff  <= magr_prod;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               mag2_ff  <= {1'b0, sqa_ff} + {1'b0, sqb_ff};
               state_ff <= S_RUN1;
            end
            S_RUN1: begin
               state_ff <= S_WAIT1;
            end
            S_WAIT1: begin
               if (!sq_busy && !dvp_busy && !dvr_busy && !cd_busy) begin
                  accr_ff  <= roll_neg_ff ? cd_z_neg : cd_z;
                  incp_ff  <= gpn_ff ? -qp_s : qp_s;
                  incr_ff  <= grn_ff ? -qr_s : qr_s;
                  state_ff <= S_RUN2;
               end
            end
            S_RUN2: begin
               state_ff <= S_WAIT2;
            end
            S_WAIT2: begin
               if (!cd_busy) begin
                  accp_ff  <= pitch_neg_ff ? cd_z_neg : cd_z;
                  bstep_ff <= '0;
                  state_ff <= S_BLEND;
               end
            end
            S_BLEND: begin
               prod_ff  <= prod_in;
               bstep_ff <= bstep_ff + 3'd1;
               unique case (bstep_ff)
                  3'd1, 3'd3: sum_ff <= prod_ff;
                  3'd2: pitch_ff <= bsat;
                  3'd4: begin
                     roll_ff  <= bsat;
                     last_ff  <= now_ff;
                     vflag_ff <= (ax_ff != '0) || (ay_ff != '0) || (az_ff != '0);
                     state_ff <= S_DONE;
                  end
                  default: ;
               endcase
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pitch_ff <= pitch_ff;
                  rsp_roll_ff  <= roll_ff;
                  rsp_sv_ff    <= vflag_ff;
                  rsp_uo_ff    <= ok_ff & vflag_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pitch_angle  = rsp_pitch_ff;
   assign rsp_roll_angle   = rsp_roll_ff;
   assign rsp_sample_valid = rsp_sv_ff;
   assign rsp_update_ok    = rsp_uo_ff;

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat taken while one is in work");

   a_failed_read_fast: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_read_ok) |=> (state_ff == S_DONE))
      else $error("failed read did not go straight to result");

   a_update_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_update_ok || rsp_sample_valid))
      else $error("update_ok without sample_valid");

   a_units_idle_in_pitch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT2) |-> (!sq_busy && !dvp_busy && !dvr_busy))
      else $error("root or divider still busy during pitch pass");
`endif

endmodule
